// File: hw/rtl/cacs_pkg.sv
// Package: shared types, constants and the phase step function of the cell update
`timescale 1ns / 1ps

package cacs_pkg;

	localparam int TIME_BITS  = 32;
	localparam int PERIOD_W   = 32;
	localparam int SIM_W      = 40;
	localparam int CFG_W      = 40;
	localparam int CFG_IDX_W  = 3;
	localparam int DIV_BITS   = 2;
	localparam int DIV_CYCLES = SIM_W / DIV_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

	localparam logic [CFG_IDX_W-1:0] CFG_FORCE_ONE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FORCE_TWO   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FORCE_THREE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FORCE_FOUR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STIM_START  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STIM_PERIOD = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 3'd6;

	localparam logic ACT_NEIGHBOUR = 1'b0;
	localparam logic ACT_CELL      = 1'b1;

	localparam logic [1:0] COND_DEAD = 2'd1;
	localparam logic [1:0] COND_PACE = 2'd2;

	localparam logic [2:0] PH_0 = 3'd0;
	localparam logic [2:0] PH_1 = 3'd1;
	localparam logic [2:0] PH_2 = 3'd2;
	localparam logic [2:0] PH_4 = 3'd4;

	localparam logic [1:0] COUNT_ONE = 2'd1;
	localparam logic [1:0] COUNT_MAX = 2'd2;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [3:0][TIME_BITS-1:0] time_quad_t;

	typedef struct packed {
		time_quad_t           force_time;
		logic [SIM_W-1:0]     stim_start;
		logic [PERIOD_W-1:0]  stim_period;
		time_t                time_step;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       cond;
		logic [2:0]       v_phase;
		logic [2:0]       f_phase;
		time_t            t;
		time_quad_t       ap_time;
		logic [SIM_W-1:0] sim_time;
		logic [1:0]       count;
	} cell_item_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_OUT
	} back_state_t;

	function automatic logic [2:0] step_phase(input logic [2:0] ph, input time_t t,
			input time_quad_t ends);
		logic [1:0] idx;
		logic [2:0] res;
		idx = ph[1:0] - 2'd1;
		res = ph;
		if (ph != PH_0 && ph <= PH_4) begin
			if (t >= ends[idx]) begin
				res = (ph == PH_4) ? PH_0 : ph + 3'd1;
			end
		end
		return res;
	endfunction

endpackage

// File: hw/rtl/cacs_front.sv
// Front end: accepts items, counts stimulating neighbours, forwards cell items
`timescale 1ns / 1ps

module cacs_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  action,
	input  logic [1:0]            cell_cond,
	input  logic [2:0]            v_phase,
	input  logic [2:0]            f_phase,
	input  cacs_pkg::time_t       phase_time,
	input  cacs_pkg::time_t       prop_time,
	input  cacs_pkg::time_t       ap_time_one,
	input  cacs_pkg::time_t       ap_time_two,
	input  cacs_pkg::time_t       ap_time_three,
	input  cacs_pkg::time_t       ap_time_four,
	input  logic [cacs_pkg::SIM_W-1:0] sim_time,
	input  logic                  q_full,
	output logic                  q_push,
	output cacs_pkg::cell_item_t  q_item
);

	logic [1:0] count_q;
	logic       accept;
	logic       stimulates;

	assign in_ready   = !q_full;
	assign accept     = in_valid && in_ready;
	assign stimulates = (v_phase == cacs_pkg::PH_1 || v_phase == cacs_pkg::PH_2)
		&& (phase_time >= prop_time) && (count_q < cacs_pkg::COUNT_MAX);
	assign q_push     = accept && (action == cacs_pkg::ACT_CELL);

	always_comb begin
		q_item.cond     = cell_cond;
		q_item.v_phase  = v_phase;
		q_item.f_phase  = f_phase;
		q_item.t        = phase_time;
		q_item.ap_time  = {ap_time_four, ap_time_three, ap_time_two, ap_time_one};
		q_item.sim_time = sim_time;
		q_item.count    = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (action == cacs_pkg::ACT_CELL) begin
				count_q <= '0;
			end else if (stimulates) begin
				count_q <= count_q + 2'd1;
			end
		end
	end

endmodule

// File: hw/rtl/cacs_queue.sv
// Two-entry queue of cell items between front and back end
`timescale 1ns / 1ps

module cacs_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cacs_pkg::cell_item_t push_item,
	input  logic                 pop,
	output logic                 full,
	output logic                 valid,
	output cacs_pkg::cell_item_t head
);

	cacs_pkg::cell_item_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full  = (fill_q == 2'd2);
	assign valid = (fill_q != 2'd0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// File: hw/rtl/cacs_back.sv
// Back end: pacemaker remainder unit, cell state update and result register
`timescale 1ns / 1ps

module cacs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cacs_pkg::cfg_t       cfg,
	input  logic                 q_valid,
	input  cacs_pkg::cell_item_t q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           new_v_phase,
	output logic [2:0]           new_f_phase,
	output cacs_pkg::time_t      new_cell_time,
	output logic                 activated,
	output logic [1:0]           stim_count
);

	cacs_pkg::back_state_t state_q, state_d;
	cacs_pkg::cell_item_t  item_q;
	logic                  due_q;
	logic [cacs_pkg::SIM_W-1:0]    dvd_q, dvd_d;
	logic [cacs_pkg::PERIOD_W-1:0] rem_q, rem_d;
	logic [cacs_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                  out_valid_q;
	logic [2:0]            nv_q, nf_q;
	cacs_pkg::time_t       nt_q;
	logic                  act_q;
	logic [1:0]            count_out_q;

	logic                  out_write;
	logic                  load;
	logic                  head_pace;
	logic                  head_started;
	logic                  period_zero;
	logic                  need_div;
	logic                  div_last;
	logic [cacs_pkg::PERIOD_W:0] trial;

	logic [2:0]            nv, nf;
	cacs_pkg::time_t       nt;
	logic                  act;
	logic                  go;
	logic [cacs_pkg::TIME_BITS:0] sum;

	assign out_write    = (state_q == cacs_pkg::BK_OUT) && (!out_valid_q || out_ready);
	assign load         = q_valid && ((state_q == cacs_pkg::BK_IDLE) || out_write);
	assign q_pop        = load;
	assign head_pace    = (q_head.cond == cacs_pkg::COND_PACE);
	assign head_started = (q_head.sim_time >= cfg.stim_start);
	assign period_zero  = (cfg.stim_period == '0);
	assign need_div     = head_pace && head_started && !period_zero;
	assign div_last     = (cnt_q == cacs_pkg::DIV_CNT_W'(cacs_pkg::DIV_CYCLES - 1));

	always_comb begin
		rem_d = rem_q;
		dvd_d = dvd_q;
		trial = '0;
		for (int k = 0; k < cacs_pkg::DIV_BITS; k++) begin
			trial = {rem_d, dvd_d[cacs_pkg::SIM_W-1]};
			if (trial >= {1'b0, cfg.stim_period}) begin
				trial = trial - {1'b0, cfg.stim_period};
			end
			rem_d = trial[cacs_pkg::PERIOD_W-1:0];
			dvd_d = {dvd_d[cacs_pkg::SIM_W-2:0], 1'b0};
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cacs_pkg::BK_IDLE: begin
				if (load) begin
					state_d = need_div ? cacs_pkg::BK_DIV : cacs_pkg::BK_OUT;
				end
			end
			cacs_pkg::BK_DIV: begin
				if (div_last) begin
					state_d = cacs_pkg::BK_OUT;
				end
			end
			cacs_pkg::BK_OUT: begin
				if (load) begin
					state_d = need_div ? cacs_pkg::BK_DIV : cacs_pkg::BK_OUT;
				end else if (out_write) begin
					state_d = cacs_pkg::BK_IDLE;
				end
			end
			default: state_d = cacs_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cacs_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= '0;
		end else if (state_q == cacs_pkg::BK_DIV) begin
			cnt_q <= cnt_q + cacs_pkg::DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= q_head;
			due_q  <= head_pace && head_started && period_zero;
			dvd_q  <= q_head.sim_time - cfg.stim_start;
			rem_q  <= '0;
		end else if (state_q == cacs_pkg::BK_DIV) begin
			dvd_q <= dvd_d;
			rem_q <= rem_d;
			if (div_last) begin
				due_q <= (rem_d <= cfg.time_step);
			end
		end
	end

	always_comb begin
		nv  = item_q.v_phase;
		nf  = item_q.f_phase;
		nt  = item_q.t;
		act = 1'b0;
		sum = {1'b0, item_q.t} + {1'b0, cfg.time_step};
		go  = ((item_q.cond == cacs_pkg::COND_PACE) && due_q)
			|| ((item_q.v_phase == cacs_pkg::PH_0) && (item_q.count >= cacs_pkg::COUNT_ONE))
			|| ((item_q.v_phase == cacs_pkg::PH_4) && (item_q.count >= cacs_pkg::COUNT_MAX));
		if (item_q.cond != cacs_pkg::COND_DEAD) begin
			if (go) begin
				act = 1'b1;
				nv  = cacs_pkg::PH_1;
				nf  = cacs_pkg::PH_1;
				nt  = '0;
			end else begin
				if (!(item_q.v_phase == cacs_pkg::PH_0 && item_q.f_phase == cacs_pkg::PH_0)) begin
					nt = sum[cacs_pkg::TIME_BITS] ? '1 : sum[cacs_pkg::TIME_BITS-1:0];
				end
				nv = cacs_pkg::step_phase(item_q.v_phase, item_q.t, item_q.ap_time);
				nf = cacs_pkg::step_phase(item_q.f_phase, item_q.t, cfg.force_time);
				if (item_q.f_phase == cacs_pkg::PH_4 && nf == cacs_pkg::PH_0) begin
					nv = cacs_pkg::PH_0;
					nt = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_write) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_write) begin
			nv_q        <= nv;
			nf_q        <= nf;
			nt_q        <= nt;
			act_q       <= act;
			count_out_q <= item_q.count;
		end
	end

	assign out_valid     = out_valid_q;
	assign new_v_phase   = nv_q;
	assign new_f_phase   = nf_q;
	assign new_cell_time = nt_q;
	assign activated     = act_q;
	assign stim_count    = count_out_q;

endmodule

// File: hw/rtl/cardiac_automaton_cell_step.sv
// Top level: cardiac automaton cell update with configuration registers
//
//   channel  | handshake              | carries
//   ---------+------------------------+-----------------------------------------
//   in       | in_valid / in_ready    | neighbour items and cell items
//   out      | out_valid / out_ready  | one result per cell item
//   cfg      | cfg_we                 | register index and data, no read-back
//
// Neighbour items are taken one per cycle while the two-entry cell queue has room.
// A cell item leaves the queue into the back end item register and is then registered at the output.
// A pacemaker cell at or past the stimulus start with a nonzero period first passes
// through the remainder unit, which resolves two dividend bits per cycle.
// Reset clears the neighbour count, queue, back end state and output valid.
// A stalled output holds the back end; the queue then fills and drops in_ready.
`timescale 1ns / 1ps

module cardiac_automaton_cell_step (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [cacs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cacs_pkg::CFG_W-1:0]     cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      action,
	input  logic [1:0]                cell_cond,
	input  logic [2:0]                v_phase,
	input  logic [2:0]                f_phase,
	input  cacs_pkg::time_t           phase_time,
	input  cacs_pkg::time_t           prop_time,
	input  cacs_pkg::time_t           ap_time_one,
	input  cacs_pkg::time_t           ap_time_two,
	input  cacs_pkg::time_t           ap_time_three,
	input  cacs_pkg::time_t           ap_time_four,
	input  logic [cacs_pkg::SIM_W-1:0] sim_time,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [2:0]                new_v_phase,
	output logic [2:0]                new_f_phase,
	output cacs_pkg::time_t           new_cell_time,
	output logic                      activated,
	output logic [1:0]                stim_count
);

	cacs_pkg::cfg_t       cfg_q;
	logic                 q_full;
	logic                 q_push;
	logic                 q_pop;
	logic                 q_valid;
	cacs_pkg::cell_item_t q_item;
	cacs_pkg::cell_item_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.force_time  <= '0;
			cfg_q.stim_start  <= '0;
			cfg_q.stim_period <= cacs_pkg::PERIOD_W'(1);
			cfg_q.time_step   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cacs_pkg::CFG_FORCE_ONE:   cfg_q.force_time[0] <= cfg_data[cacs_pkg::TIME_BITS-1:0];
				cacs_pkg::CFG_FORCE_TWO:   cfg_q.force_time[1] <= cfg_data[cacs_pkg::TIME_BITS-1:0];
				cacs_pkg::CFG_FORCE_THREE: cfg_q.force_time[2] <= cfg_data[cacs_pkg::TIME_BITS-1:0];
				cacs_pkg::CFG_FORCE_FOUR:  cfg_q.force_time[3] <= cfg_data[cacs_pkg::TIME_BITS-1:0];
				cacs_pkg::CFG_STIM_START:  cfg_q.stim_start    <= cfg_data[cacs_pkg::SIM_W-1:0];
				cacs_pkg::CFG_STIM_PERIOD: cfg_q.stim_period   <= cfg_data[cacs_pkg::PERIOD_W-1:0];
				cacs_pkg::CFG_TIME_STEP:   cfg_q.time_step     <= cfg_data[cacs_pkg::TIME_BITS-1:0];
				default: ;
			endcase
		end
	end

	cacs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.cell_cond     (cell_cond),
		.v_phase       (v_phase),
		.f_phase       (f_phase),
		.phase_time    (phase_time),
		.prop_time     (prop_time),
		.ap_time_one   (ap_time_one),
		.ap_time_two   (ap_time_two),
		.ap_time_three (ap_time_three),
		.ap_time_four  (ap_time_four),
		.sim_time      (sim_time),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (q_item)
	);

	cacs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.pop       (q_pop),
		.full      (q_full),
		.valid     (q_valid),
		.head      (q_head)
	);

	cacs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.new_v_phase   (new_v_phase),
		.new_f_phase   (new_f_phase),
		.new_cell_time (new_cell_time),
		.activated     (activated),
		.stim_count    (stim_count)
	);

endmodule

// File: hw/rtl/cacs_checker.sv
// Checker on the top level ports of the cell update, with its bind
`timescale 1ns / 1ps

module cacs_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [2:0]           new_v_phase,
	input logic [2:0]           new_f_phase,
	input cacs_pkg::time_t      new_cell_time,
	input logic                 activated,
	input logic [1:0]           stim_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(new_cell_time)
			&& $stable(activated) && $stable(stim_count))
		else $error("result transaction changed while stalled");

	a_act_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && activated |-> new_v_phase == cacs_pkg::PH_1
			&& new_f_phase == cacs_pkg::PH_1 && new_cell_time == '0)
		else $error("activated cell does not restart in phase one");

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stim_count <= cacs_pkg::COUNT_MAX)
		else $error("neighbour count exceeded saturation");

endmodule

bind cardiac_automaton_cell_step cacs_checker u_cacs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.new_v_phase   (new_v_phase),
	.new_f_phase   (new_f_phase),
	.new_cell_time (new_cell_time),
	.activated     (activated),
	.stim_count    (stim_count)
);

// File: verif/cardiac_automaton_cell_step_test.sv
// Testbench: directed and random cell updates checked against an in-bench cell predictor
`timescale 1ns / 1ps

module cardiac_automaton_cell_step_test;

	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          SETTLE_WAIT  = 30;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          PHASE_ITEMS  = 156;
	localparam logic [1:0]  COND_NORMAL  = 2'd0;
	localparam logic [1:0]  COND_SPARE   = 2'd3;
	localparam logic [2:0]  PH_3         = 3'd3;
	localparam logic [2:0]  PH_5         = 3'd5;
	localparam logic [2:0]  PH_JUNK      = 3'd7;

	typedef struct packed {
		logic                       action;
		logic [1:0]                 cond;
		logic [2:0]                 v_ph;
		logic [2:0]                 f_ph;
		cacs_pkg::time_t            phase_t;
		cacs_pkg::time_t            prop_t;
		cacs_pkg::time_quad_t       ap_end;
		logic [cacs_pkg::SIM_W-1:0] sim_t;
	} stim_item_t;

	typedef struct packed {
		logic [2:0]      v;
		logic [2:0]      f;
		cacs_pkg::time_t t;
		logic            act;
		logic [1:0]      count;
	} cell_outcome_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [cacs_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [cacs_pkg::CFG_W-1:0]     cfg_data;
	logic                           in_valid;
	logic                           in_ready;
	logic                           action;
	logic [1:0]                     cell_cond;
	logic [2:0]                     v_phase;
	logic [2:0]                     f_phase;
	cacs_pkg::time_t                phase_time;
	cacs_pkg::time_t                prop_time;
	cacs_pkg::time_t                ap_time_one;
	cacs_pkg::time_t                ap_time_two;
	cacs_pkg::time_t                ap_time_three;
	cacs_pkg::time_t                ap_time_four;
	logic [cacs_pkg::SIM_W-1:0]     sim_time;
	logic                           out_valid;
	logic                           out_ready;
	logic [2:0]                     new_v_phase;
	logic [2:0]                     new_f_phase;
	cacs_pkg::time_t                new_cell_time;
	logic                           activated;
	logic [1:0]                     stim_count;

	cacs_pkg::time_quad_t           force_end;
	logic [cacs_pkg::SIM_W-1:0]     pace_start;
	logic [cacs_pkg::PERIOD_W-1:0]  pace_period;
	cacs_pkg::time_t                dt_step;
	logic [1:0]                     nbr_count;

	cell_outcome_t         cell_results_due[$];
	int                    mismatch_count;
	int                    cycle_count;
	int                    burst_left;
	bit                    sender_steady;
	bit                    hold_request;

	cardiac_automaton_cell_step dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.cell_cond(cell_cond),
		.v_phase(v_phase),
		.f_phase(f_phase),
		.phase_time(phase_time),
		.prop_time(prop_time),
		.ap_time_one(ap_time_one),
		.ap_time_two(ap_time_two),
		.ap_time_three(ap_time_three),
		.ap_time_four(ap_time_four),
		.sim_time(sim_time),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.new_v_phase(new_v_phase),
		.new_f_phase(new_f_phase),
		.new_cell_time(new_cell_time),
		.activated(activated),
		.stim_count(stim_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [2:0] next_phase(input logic [2:0] ph, input cacs_pkg::time_t t,
			input cacs_pkg::time_quad_t ends);
		logic [2:0] nxt;
		nxt = ph;
		if (ph >= cacs_pkg::PH_1 && ph <= cacs_pkg::PH_4
				&& t >= ends[2'(ph - cacs_pkg::PH_1)]) begin
			nxt = (ph == cacs_pkg::PH_4) ? cacs_pkg::PH_0 : ph + 3'd1;
		end
		return nxt;
	endfunction

	function automatic logic pacer_due(input logic [cacs_pkg::SIM_W-1:0] now);
		logic [cacs_pkg::SIM_W-1:0] since;
		logic [cacs_pkg::SIM_W-1:0] rem;
		if (now < pace_start) return 1'b0;
		since = now - pace_start;
		rem = (pace_period == 0) ? '0 : since % {8'd0, pace_period};
		return rem <= {8'd0, dt_step};
	endfunction

	function automatic cell_outcome_t settle_cell(input stim_item_t it, input logic [1:0] cnt);
		cell_outcome_t o;
		logic          go;
		logic [32:0]   sum;
		o.v = it.v_ph;
		o.f = it.f_ph;
		o.t = it.phase_t;
		o.act = 1'b0;
		o.count = cnt;
		if (it.cond != cacs_pkg::COND_DEAD) begin
			go = (it.cond == cacs_pkg::COND_PACE && pacer_due(it.sim_t))
				|| (it.v_ph == cacs_pkg::PH_0 && cnt >= cacs_pkg::COUNT_ONE)
				|| (it.v_ph == cacs_pkg::PH_4 && cnt >= cacs_pkg::COUNT_MAX);
			if (go) begin
				o.v = cacs_pkg::PH_1;
				o.f = cacs_pkg::PH_1;
				o.t = '0;
				o.act = 1'b1;
			end else begin
				if (!(it.v_ph == cacs_pkg::PH_0 && it.f_ph == cacs_pkg::PH_0)) begin
					sum = {1'b0, it.phase_t} + {1'b0, dt_step};
					o.t = sum[32] ? '1 : sum[31:0];
				end
				o.v = next_phase(it.v_ph, it.phase_t, it.ap_end);
				o.f = next_phase(it.f_ph, it.phase_t, force_end);
				if (it.f_ph == cacs_pkg::PH_4 && o.f == cacs_pkg::PH_0) begin
					o.v = cacs_pkg::PH_0;
					o.t = '0;
				end
			end
		end
		return o;
	endfunction

	task automatic absorb_item(input stim_item_t it);
		if (it.action == cacs_pkg::ACT_NEIGHBOUR) begin
			if ((it.v_ph == cacs_pkg::PH_1 || it.v_ph == cacs_pkg::PH_2)
					&& it.phase_t >= it.prop_t && nbr_count < cacs_pkg::COUNT_MAX) begin
				nbr_count++;
			end
		end else begin
			cell_results_due.push_back(settle_cell(it, nbr_count));
			nbr_count = '0;
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [39:0] got,
			input logic [39:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		cell_outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (cell_results_due.size() == 0) begin
				flag_mismatch("result with none due", 40'(new_cell_time), '0);
			end else begin
				want = cell_results_due.pop_front();
				if (new_v_phase !== want.v)
					flag_mismatch("new_v_phase", 40'(new_v_phase), 40'(want.v));
				if (new_f_phase !== want.f)
					flag_mismatch("new_f_phase", 40'(new_f_phase), 40'(want.f));
				if (new_cell_time !== want.t)
					flag_mismatch("new_cell_time", 40'(new_cell_time), 40'(want.t));
				if (activated !== want.act)
					flag_mismatch("activated", 40'(activated), 40'(want.act));
				if (stim_count !== want.count)
					flag_mismatch("stim_count", 40'(stim_count), 40'(want.count));
			end
		end
	end

	// result side: rotating stall patterns, plus a long hold-off on request
	initial begin
		int          mode_left;
		int          ready_mode;
		logic [1:0]  beat;
		mode_left = 0;
		ready_mode = 0;
		beat = '0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					ready_mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				beat++;
				case (ready_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (beat == 2'd0);
					default: out_ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	task automatic offer_item(input stim_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = sender_steady ? 0 : $urandom_range(0, 6);
			burst_left = $urandom_range(1, 20);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		action <= it.action;
		cell_cond <= it.cond;
		v_phase <= it.v_ph;
		f_phase <= it.f_ph;
		phase_time <= it.phase_t;
		prop_time <= it.prop_t;
		ap_time_one <= it.ap_end[0];
		ap_time_two <= it.ap_end[1];
		ap_time_three <= it.ap_end[2];
		ap_time_four <= it.ap_end[3];
		sim_time <= it.sim_t;
		do @(posedge clk); while (!in_ready);
		absorb_item(it);
	endtask

	// drop valid, drain every result, then let a pacemaker division finish
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (cell_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(input logic [cacs_pkg::CFG_IDX_W-1:0] idx,
			input logic [cacs_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			cacs_pkg::CFG_FORCE_ONE:   force_end[0] = data[31:0];
			cacs_pkg::CFG_FORCE_TWO:   force_end[1] = data[31:0];
			cacs_pkg::CFG_FORCE_THREE: force_end[2] = data[31:0];
			cacs_pkg::CFG_FORCE_FOUR:  force_end[3] = data[31:0];
			cacs_pkg::CFG_STIM_START:  pace_start = data;
			cacs_pkg::CFG_STIM_PERIOD: pace_period = data[31:0];
			cacs_pkg::CFG_TIME_STEP:   dt_step = data[31:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [cacs_pkg::CFG_W-1:0] f1,
			input logic [cacs_pkg::CFG_W-1:0] f2,
			input logic [cacs_pkg::CFG_W-1:0] f3, input logic [cacs_pkg::CFG_W-1:0] f4,
			input logic [cacs_pkg::CFG_W-1:0] start, input logic [cacs_pkg::CFG_W-1:0] period,
			input logic [cacs_pkg::CFG_W-1:0] dt);
		write_reg(cacs_pkg::CFG_FORCE_ONE, f1);
		write_reg(cacs_pkg::CFG_FORCE_TWO, f2);
		write_reg(cacs_pkg::CFG_FORCE_THREE, f3);
		write_reg(cacs_pkg::CFG_FORCE_FOUR, f4);
		write_reg(cacs_pkg::CFG_STIM_START, start);
		write_reg(cacs_pkg::CFG_STIM_PERIOD, period);
		write_reg(cacs_pkg::CFG_TIME_STEP, dt);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic stim_item_t make_nbr(input logic [2:0] v, input cacs_pkg::time_t t,
			input cacs_pkg::time_t prop);
		stim_item_t it;
		it.action = cacs_pkg::ACT_NEIGHBOUR;
		it.cond = 2'($urandom_range(0, 3));
		it.v_ph = v;
		it.f_ph = 3'($urandom_range(0, 7));
		it.phase_t = t;
		it.prop_t = prop;
		it.ap_end = {$urandom, $urandom, $urandom, $urandom};
		it.sim_t = cacs_pkg::SIM_W'({$urandom, $urandom});
		return it;
	endfunction

	function automatic stim_item_t make_cell(input logic [1:0] cond, input logic [2:0] v,
			input logic [2:0] f, input cacs_pkg::time_t t, input cacs_pkg::time_quad_t ap,
			input logic [cacs_pkg::SIM_W-1:0] sim);
		stim_item_t it;
		it.action = cacs_pkg::ACT_CELL;
		it.cond = cond;
		it.v_ph = v;
		it.f_ph = f;
		it.phase_t = t;
		it.prop_t = $urandom;
		it.ap_end = ap;
		it.sim_t = sim;
		return it;
	endfunction

	function automatic cacs_pkg::time_t near(input cacs_pkg::time_t pivot);
		case ($urandom_range(0, 5))
			0: return pivot - 32'd1;
			1: return pivot;
			2: return pivot + 32'd1;
			3: return '0;
			4: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_phase();
		return ($urandom_range(0, 15) < 14) ? 3'($urandom_range(0, 4))
			: 3'($urandom_range(5, 7));
	endfunction

	task automatic send_random_group(input int max_nbrs);
		stim_item_t                 it;
		logic [1:0]                 cond;
		logic [2:0]                 v;
		logic [2:0]                 f;
		cacs_pkg::time_t            pivot;
		cacs_pkg::time_quad_t       ap;
		logic [cacs_pkg::SIM_W-1:0] sim;
		logic [cacs_pkg::SIM_W-1:0] k;
		logic [cacs_pkg::SIM_W-1:0] off;
		int                         n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : $urandom_range(0, max_nbrs);
		repeat (n) begin
			pivot = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 100);
			v = ($urandom_range(0, 2) != 0) ? 3'($urandom_range(1, 2))
				: 3'($urandom_range(0, 7));
			offer_item(make_nbr(v, near(pivot), pivot));
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: cond = COND_NORMAL;
			5, 6, 7: cond = cacs_pkg::COND_PACE;
			8: cond = cacs_pkg::COND_DEAD;
			default: cond = COND_SPARE;
		endcase
		v = pick_phase();
		f = pick_phase();
		ap = {$urandom, $urandom, $urandom, $urandom};
		if (v >= cacs_pkg::PH_1 && v <= cacs_pkg::PH_4 && $urandom_range(0, 1))
			pivot = ap[2'(v - cacs_pkg::PH_1)];
		else if (f >= cacs_pkg::PH_1 && f <= cacs_pkg::PH_4)
			pivot = force_end[2'(f - cacs_pkg::PH_1)];
		else pivot = $urandom;
		if ($urandom_range(0, 2) != 0) begin
			k = cacs_pkg::SIM_W'($urandom_range(0, 1000));
			case ($urandom_range(0, 3))
				0: off = '0;
				1: off = {8'd0, dt_step};
				2: off = {8'd0, dt_step} + 40'd1;
				default: off = cacs_pkg::SIM_W'($urandom_range(0, 7));
			endcase
			sim = pace_start + k * {8'd0, pace_period} + off;
		end else begin
			case ($urandom_range(0, 3))
				0: sim = '1;
				1: sim = pace_start - 40'd1;
				default: sim = cacs_pkg::SIM_W'({$urandom, $urandom});
			endcase
		end
		it = make_cell(cond, v, f, near(pivot), ap, sim);
		offer_item(it);
	endtask

	task automatic test_neighbour_counting();
		cacs_pkg::time_quad_t ap_hi;
		ap_hi = '1;
		offer_item(make_nbr(cacs_pkg::PH_1, 32'd5, 32'd5));
		offer_item(make_nbr(cacs_pkg::PH_2, 32'd4, 32'd5));
		offer_item(make_cell(COND_NORMAL, cacs_pkg::PH_0, cacs_pkg::PH_0, 32'd100, ap_hi, '0));
		offer_item(make_nbr(cacs_pkg::PH_2, '1, '0));
		offer_item(make_nbr(cacs_pkg::PH_1, '0, '0));
		offer_item(make_nbr(cacs_pkg::PH_1, 32'd1, '0));
		offer_item(make_cell(COND_NORMAL, cacs_pkg::PH_4, cacs_pkg::PH_0, '0, ap_hi, '0));
		offer_item(make_nbr(PH_3, '1, '0));
		offer_item(make_nbr(cacs_pkg::PH_0, '1, '0));
		offer_item(make_nbr(PH_JUNK, '1, '0));
		offer_item(make_nbr(cacs_pkg::PH_1, '1, '0));
		offer_item(make_cell(COND_NORMAL, cacs_pkg::PH_4, cacs_pkg::PH_1, '0, ap_hi, '0));
	endtask

	task automatic test_phase_stepping();
		cacs_pkg::time_quad_t ap;
		ap[0] = 32'd10;
		ap[1] = 32'd150;
		ap[2] = 32'd250;
		ap[3] = 32'd350;
		settle();
		program_regs(40'd100, 40'd200, 40'd300, 40'd400, 40'd1000, 40'd50, 40'hFF_FFFF_FFFF);
		offer_item(make_cell(COND_NORMAL, cacs_pkg::PH_1, cacs_pkg::PH_1, 32'hFFFF_FFF0, ap,
			'0));
		offer_item(make_cell(COND_NORMAL, cacs_pkg::PH_0, cacs_pkg::PH_0, 32'd77, ap, '0));
		offer_item(make_cell(COND_NORMAL, PH_3, cacs_pkg::PH_4, 32'd500, ap, '0));
		offer_item(make_cell(COND_NORMAL, PH_5, PH_JUNK, 32'd150, ap, '0));
		offer_item(make_nbr(cacs_pkg::PH_1, 32'd9, 32'd9));
		offer_item(make_nbr(cacs_pkg::PH_2, 32'd9, 32'd9));
		offer_item(make_cell(cacs_pkg::COND_DEAD, cacs_pkg::PH_0, cacs_pkg::PH_2, 32'd250, ap,
			'0));
		offer_item(make_nbr(cacs_pkg::PH_2, '0, '0));
		offer_item(make_cell(COND_SPARE, cacs_pkg::PH_0, PH_3, 32'd5, ap, '0));
		offer_item(make_cell(cacs_pkg::COND_PACE, cacs_pkg::PH_2, cacs_pkg::PH_2, 32'd120, ap,
			40'd999));
	endtask

	task automatic test_pacemaker();
		cacs_pkg::time_quad_t ap;
		ap = '1;
		settle();
		program_regs('0, '0, '0, '0, 40'd1000, 40'd50, 40'd5);
		offer_item(make_cell(cacs_pkg::COND_PACE, cacs_pkg::PH_2, cacs_pkg::PH_2, 32'd7, ap,
			40'd1055));
		offer_item(make_cell(cacs_pkg::COND_PACE, cacs_pkg::PH_2, cacs_pkg::PH_2, 32'd7, ap,
			40'd1056));
		offer_item(make_cell(cacs_pkg::COND_PACE, PH_3, cacs_pkg::PH_1, 32'd7, ap,
			40'hFF_FFFF_FFFF));
		settle();
		// zero period: due on every cell item once past the start
		program_regs('0, '0, '0, '0, '0, '0, '0);
		offer_item(make_cell(cacs_pkg::COND_PACE, PH_3, PH_3, 32'd9, ap,
			cacs_pkg::SIM_W'({$urandom, $urandom})));
	endtask

	task automatic test_backpressure();
		hold_request = 1'b1;
		sender_steady = 1'b1;
		repeat (12) send_random_group(3);
		sender_steady = 1'b0;
	endtask

	task automatic test_random_cells();
		int phase;
		for (phase = 0; phase < 6; phase++) begin
			settle();
			case (phase)
				0: program_regs('0, '0, '0, '0, '0, 40'd1, '0);
				1: program_regs('1, '1, '1, '1, '1, '1, '1);
				2: program_regs(cacs_pkg::CFG_W'($urandom_range(0, 1000)),
						cacs_pkg::CFG_W'($urandom_range(1000, 5000)),
						cacs_pkg::CFG_W'($urandom_range(5000, 20000)),
						cacs_pkg::CFG_W'($urandom_range(20000, 90000)),
						cacs_pkg::CFG_W'({$urandom, $urandom}),
						cacs_pkg::CFG_W'($urandom_range(1, 1000)),
						cacs_pkg::CFG_W'($urandom_range(0, 50)));
				3: program_regs(cacs_pkg::CFG_W'($urandom), cacs_pkg::CFG_W'($urandom),
						cacs_pkg::CFG_W'($urandom), cacs_pkg::CFG_W'($urandom),
						'0, '0, '0);
				4: program_regs(cacs_pkg::CFG_W'({$urandom, $urandom}),
						cacs_pkg::CFG_W'({$urandom, $urandom}),
						cacs_pkg::CFG_W'({$urandom, $urandom}),
						cacs_pkg::CFG_W'({$urandom, $urandom}),
						cacs_pkg::CFG_W'({$urandom, $urandom}),
						cacs_pkg::CFG_W'({$urandom, $urandom}),
						cacs_pkg::CFG_W'({$urandom, $urandom}));
				default: program_regs(cacs_pkg::CFG_W'($urandom), cacs_pkg::CFG_W'($urandom),
						cacs_pkg::CFG_W'($urandom), cacs_pkg::CFG_W'($urandom),
						cacs_pkg::CFG_W'({$urandom, $urandom}), 40'hFFFF_FFFF,
						cacs_pkg::CFG_W'($urandom));
			endcase
			sender_steady = phase[0];
			begin
				int sent;
				sent = 0;
				while (sent < PHASE_ITEMS) begin
					send_random_group(3);
					sent += 2;
				end
			end
		end
		sender_steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		action = cacs_pkg::ACT_NEIGHBOUR;
		cell_cond = COND_NORMAL;
		v_phase = cacs_pkg::PH_0;
		f_phase = cacs_pkg::PH_0;
		phase_time = '0;
		prop_time = '0;
		ap_time_one = '0;
		ap_time_two = '0;
		ap_time_three = '0;
		ap_time_four = '0;
		sim_time = '0;
		force_end = '0;
		pace_start = '0;
		pace_period = 32'd1;
		dt_step = '0;
		nbr_count = '0;
		mismatch_count = 0;
		cycle_count = 0;
		burst_left = 0;
		sender_steady = 1'b0;
		hold_request = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_neighbour_counting();
		test_phase_stepping();
		test_pacemaker();
		test_backpressure();
		test_random_cells();
		settle();
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
